// File: rtl/gbi_pkg.sv
`default_nettype none

package gbi_pkg;

   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      OP_LOAD_COL  = 2'd0,
      OP_LOAD_ROW  = 2'd1,
      OP_LOAD_CELL = 2'd2,
      OP_QUERY     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_HEIGHT      = 2'd0,
      KIND_HEIGHT_FILT = 2'd1,
      KIND_NORMAL      = 2'd2,
      KIND_NORMAL_FILT = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      CSR_COLS_IN_USE = 1'b0,
      CSR_ROWS_IN_USE = 1'b1
   } csr_index_type;

   // first layer of the filtered set
   localparam logic [3:0] FILT_LAYER_BASE = 4'd4;
   localparam logic [6:0] LIMIT_RESET     = 7'd64;

   // quotient bits of the rounding divider (result magnitude stays below 2^33)
   localparam int DIV_Q_BITS = 33;

endpackage

`default_nettype wire

// File: rtl/grid_bilinear_interpolator_unit.sv
`default_nettype none

// Bilinear interpolation over a rectilinear grid of Q16.16 values.
// Transactions enter on start/req_*; one is taken when start is high and busy
// is low. Loads (column coordinate, row coordinate, grid cell) are written in
// the accepting cycle and give no response. A query finds the bracketing cell
// by stepping through the column table and then the row table, one entry per
// cycle, then runs the two-step interpolation on 32x33 multiplies and one
// shared restoring divider that retires one quotient bit per cycle.
// A query scans up to cols + rows table entries, then interpolates one layer
// for a height and three for a normal, with three divisions per layer; the
// interpolation is skipped when the point is not bracketed.
// Busy stays high until the response cycle, in which a new transaction can be
// taken, so a query occupies the block for its whole latency.
// The response sits on rsp_* for exactly one cycle, marked by rsp_strobe; the
// receiver cannot stall it. Unbracketed points return zeros with in_grid low.
// Reset returns the controller to idle and both limit registers to 64; the
// coordinate tables and grid contents are undefined until loaded.
// csr_* writes take effect at once and must only be made while idle.
module grid_bilinear_interpolator_unit #(
   parameter int MAX_COLS   = 64,
   parameter int MAX_ROWS   = 64,
   parameter int NUM_LAYERS = 8
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire gbi_pkg::opcode_type   req_opcode,
   input  wire [5:0]                  req_col_index,
   input  wire [5:0]                  req_row_index,
   input  wire [2:0]                  req_layer_sel,
   input  wire signed [31:0]          req_load_value,
   input  wire signed [31:0]          req_query_x,
   input  wire signed [31:0]          req_query_y,
   input  wire gbi_pkg::kind_type     req_query_kind,
   output logic                       rsp_strobe,
   output logic signed [31:0]         rsp_result_a,
   output logic signed [31:0]         rsp_result_b,
   output logic signed [31:0]         rsp_result_c,
   output logic                       rsp_in_grid,
   input  wire                        csr_write_enable,
   input  wire gbi_pkg::csr_index_type csr_index,
   input  wire [6:0]                  csr_write_data
);
   import gbi_pkg::*;

   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int IW    = ((CW > RW) ? CW : RW) + 1;
   localparam int CELLS = NUM_LAYERS * MAX_COLS * MAX_ROWS;
   localparam int GW    = $clog2(CELLS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_PREP, ST_FETCH0, ST_FETCH1, ST_WAIT, ST_MUL0,
      ST_MUL1, ST_ADD, ST_DIVSET, ST_DIV, ST_DIVEND, ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      STG_G0, STG_G1, STG_R
   } stage_type;

   state_type state_ff;
   stage_type stage_ff;

   logic [6:0] cols_ff, rows_ff;

   logic signed [VALUE_W-1:0] col_mem [MAX_COLS];
   logic signed [VALUE_W-1:0] row_mem [MAX_ROWS];
   logic signed [VALUE_W-1:0] grid_mem [CELLS];
   logic signed [VALUE_W-1:0] col_q_ff, row_q_ff, grid_q_ff;

   logic signed [VALUE_W-1:0] qx_ff, qy_ff;
   kind_type                  kind_ff;
   logic [IW-1:0]             nc_ff, nr_ff, rd_ff, cmp_ff;
   logic                      axis_ff, dv_ff, havep_ff;
   logic signed [VALUE_W-1:0] prev_ff, x1_ff, x2_ff, y1_ff, y2_ff;
   logic [CW-1:0]             ic_ff;
   logic [RW-1:0]             ir_ff;
   logic [VALUE_W-1:0]        dx_ff, dy_ff, wx0_ff, wx1_ff, wy0_ff, wy1_ff;
   logic [1:0]                lane_ff;
   logic signed [VALUE_W-1:0] op0_ff, op1_ff, g0_ff;
   logic signed [64:0]        prod_ff;
   logic signed [65:0]        acc_ff;
   logic                      neg_ff;
   logic [32:0]               rem_ff;
   logic [DIV_Q_BITS-1:0]     num_ff;
   logic [5:0]                dcnt_ff;

   logic                      accept;
   logic [IW-1:0]             nc_in, nr_in;
   logic [IW-1:0]             lim;
   logic signed [VALUE_W-1:0] scan_v, scan_q;
   logic                      hit;
   logic                      normal_q;
   logic [1:0]                last_lane;
   logic [3:0]                layer_cur;
   logic                      layer_ok;
   logic [CW-1:0]             rd_col;
   logic [RW-1:0]             rd_row;
   logic [GW-1:0]             rd_addr, wr_addr;
   logic                      wr_cell;
   logic [VALUE_W-1:0]        w_sel0, w_sel1, d_sel;
   logic [65:0]               mag, mrnd;
   logic [32:0]               rem_sh;
   logic                      ge;
   logic signed [VALUE_W-1:0] q_signed;
   logic signed [VALUE_W-1:0] grid_op;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign nc_in = (32'(cols_ff) < 32'(MAX_COLS)) ? IW'(cols_ff) : IW'(MAX_COLS);
   assign nr_in = (32'(rows_ff) < 32'(MAX_ROWS)) ? IW'(rows_ff) : IW'(MAX_ROWS);

   assign lim    = axis_ff ? nr_ff : nc_ff;
   assign scan_v = axis_ff ? qy_ff : qx_ff;
   assign scan_q = axis_ff ? row_q_ff : col_q_ff;
   assign hit    = dv_ff && havep_ff && (prev_ff <= scan_v) && (scan_v < scan_q);

   assign normal_q  = (kind_ff == KIND_NORMAL) || (kind_ff == KIND_NORMAL_FILT);
   assign last_lane = normal_q ? 2'd2 : 2'd0;
   always_comb begin
      layer_cur = kind_ff[0] ? FILT_LAYER_BASE : 4'd0;
      if (normal_q) begin
         layer_cur = layer_cur + 4'd1 + {2'b00, lane_ff};
      end
   end
   assign layer_ok = (32'(layer_cur) < 32'(NUM_LAYERS));

   assign rd_col  = (stage_ff == STG_G1) ? ic_ff + CW'(1) : ic_ff;
   assign rd_row  = (state_ff == ST_FETCH1) ? ir_ff + RW'(1) : ir_ff;
   assign rd_addr = GW'((32'(layer_cur) * 32'(MAX_COLS) + 32'(rd_col)) * 32'(MAX_ROWS)
                        + 32'(rd_row));
   assign wr_addr = GW'((32'(req_layer_sel) * 32'(MAX_COLS) + 32'(req_col_index))
                        * 32'(MAX_ROWS) + 32'(req_row_index));
   assign wr_cell = accept && (req_opcode == OP_LOAD_CELL)
                    && (32'(req_layer_sel) < 32'(NUM_LAYERS))
                    && (32'(req_col_index) < 32'(MAX_COLS))
                    && (32'(req_row_index) < 32'(MAX_ROWS));
   assign grid_op = layer_ok ? grid_q_ff : '0;

   assign w_sel0 = (stage_ff == STG_R) ? wx1_ff : wy1_ff;
   assign w_sel1 = (stage_ff == STG_R) ? wx0_ff : wy0_ff;
   assign d_sel  = (stage_ff == STG_R) ? dx_ff : dy_ff;

   // round half away from zero: divide |n| + d/2 by d
   assign mag      = acc_ff[65] ? 66'(-acc_ff) : 66'(acc_ff);
   assign mrnd     = mag + 66'(d_sel >> 1);
   assign rem_sh   = {rem_ff[31:0], num_ff[DIV_Q_BITS-1]};
   assign ge       = (rem_sh >= {1'b0, d_sel});
   assign q_signed = neg_ff ? -$signed(num_ff[31:0]) : $signed(num_ff[31:0]);

   always_ff @(posedge clock) begin
      if (accept && (req_opcode == OP_LOAD_COL) && (32'(req_col_index) < 32'(MAX_COLS))) begin
         col_mem[CW'(req_col_index)] <= req_load_value;
      end
      col_q_ff <= col_mem[rd_ff[CW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (accept && (req_opcode == OP_LOAD_ROW) && (32'(req_row_index) < 32'(MAX_ROWS))) begin
         row_mem[RW'(req_row_index)] <= req_load_value;
      end
      row_q_ff <= row_mem[rd_ff[RW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_cell) begin
         grid_mem[wr_addr] <= req_load_value;
      end
      grid_q_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= LIMIT_RESET;
         rows_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COLS_IN_USE: cols_ff <= csr_write_data;
            CSR_ROWS_IN_USE: rows_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_opcode == OP_QUERY)) begin
                  qx_ff        <= req_query_x;
                  qy_ff        <= req_query_y;
                  kind_ff      <= req_query_kind;
                  nc_ff        <= nc_in;
                  nr_ff        <= nr_in;
                  axis_ff      <= 1'b0;
                  rd_ff        <= '0;
                  cmp_ff       <= '0;
                  dv_ff        <= 1'b0;
                  havep_ff     <= 1'b0;
                  rsp_result_a <= '0;
                  rsp_result_b <= '0;
                  rsp_result_c <= '0;
                  rsp_in_grid  <= 1'b0;
                  state_ff     <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (rd_ff < lim) begin
                  rd_ff <= rd_ff + IW'(1);
                  dv_ff <= 1'b1;
               end else begin
                  dv_ff <= 1'b0;
               end
               if (dv_ff) begin
                  prev_ff  <= scan_q;
                  havep_ff <= 1'b1;
                  cmp_ff   <= cmp_ff + IW'(1);
               end
               if (hit) begin
                  rd_ff    <= '0;
                  cmp_ff   <= '0;
                  dv_ff    <= 1'b0;
                  havep_ff <= 1'b0;
                  if (!axis_ff) begin
                     ic_ff   <= CW'(cmp_ff - IW'(1));
                     x1_ff   <= prev_ff;
                     x2_ff   <= scan_q;
                     axis_ff <= 1'b1;
                  end else begin
                     ir_ff    <= RW'(cmp_ff - IW'(1));
                     y1_ff    <= prev_ff;
                     y2_ff    <= scan_q;
                     state_ff <= ST_PREP;
                  end
               end else if (!dv_ff && (rd_ff >= lim)) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_PREP: begin
               dx_ff       <= x2_ff - x1_ff;
               dy_ff       <= y2_ff - y1_ff;
               wx0_ff      <= qx_ff - x1_ff;
               wx1_ff      <= x2_ff - qx_ff;
               wy0_ff      <= qy_ff - y1_ff;
               wy1_ff      <= y2_ff - qy_ff;
               rsp_in_grid <= 1'b1;
               lane_ff     <= 2'd0;
               stage_ff    <= STG_G0;
               state_ff    <= ST_FETCH0;
            end
            ST_FETCH0: state_ff <= ST_FETCH1;
            ST_FETCH1: begin
               op0_ff   <= grid_op;
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               op1_ff   <= grid_op;
               state_ff <= ST_MUL0;
            end
            ST_MUL0: begin
               prod_ff  <= op0_ff * $signed({1'b0, w_sel0});
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               acc_ff   <= 66'(prod_ff);
               prod_ff  <= op1_ff * $signed({1'b0, w_sel1});
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               acc_ff   <= acc_ff + 66'(prod_ff);
               state_ff <= ST_DIVSET;
            end
            ST_DIVSET: begin
               neg_ff   <= acc_ff[65];
               rem_ff   <= mrnd[65:33];
               num_ff   <= mrnd[32:0];
               dcnt_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff  <= ge ? rem_sh - {1'b0, d_sel} : rem_sh;
               num_ff  <= {num_ff[DIV_Q_BITS-2:0], ge};
               dcnt_ff <= dcnt_ff + 6'd1;
               if (dcnt_ff == 6'(DIV_Q_BITS - 1)) begin
                  state_ff <= ST_DIVEND;
               end
            end
            ST_DIVEND: begin
               case (stage_ff)
                  STG_G0: begin
                     g0_ff    <= q_signed;
                     stage_ff <= STG_G1;
                     state_ff <= ST_FETCH0;
                  end
                  STG_G1: begin
                     op0_ff   <= g0_ff;
                     op1_ff   <= q_signed;
                     stage_ff <= STG_R;
                     state_ff <= ST_MUL0;
                  end
                  default: begin
                     case (lane_ff)
                        2'd0:    rsp_result_a <= q_signed;
                        2'd1:    rsp_result_b <= q_signed;
                        default: rsp_result_c <= q_signed;
                     endcase
                     if (lane_ff == last_lane) begin
                        state_ff <= ST_DONE;
                     end else begin
                        lane_ff  <= lane_ff + 2'd1;
                        stage_ff <= STG_G0;
                        state_ff <= ST_FETCH0;
                     end
                  end
               endcase
            end
            ST_DONE: begin
               rsp_strobe <= 1'b1;
               state_ff   <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire
